### sv/sbfr_pkg.sv
// Package: word types, microcode control word and program ROM of the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package sbfr_pkg;

    localparam int unsigned FRAME_LENGTH_DEF = 8;
    localparam logic [7:0]  START_BYTE       = 8'hAA;
    localparam int unsigned STEP_W           = 4;

    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
        logic [7:0] requested_length;
    } t_in_word;

    typedef struct packed {
        logic        frame_accepted;
        logic        frame_rejected;
        logic        fetch_status;
        logic [63:0] command_data;
    } t_out_word;

    typedef enum logic [3:0] {
        COND_ALWAYS      = 4'd0,
        COND_NOT_ACCEPT  = 4'd1,
        COND_IS_FETCH    = 4'd2,
        COND_DROP        = 4'd3,
        COND_NOT_FULL    = 4'd4,
        COND_SUM_MORE    = 4'd5,
        COND_SUM_BAD     = 4'd6,
        COND_SHIFT_MORE  = 4'd7,
        COND_OUT_BLOCKED = 4'd8
    } t_cond;

    localparam t_step STEP_WAIT    = 4'd0;
    localparam t_step STEP_DECODE  = 4'd1;
    localparam t_step STEP_APPEND  = 4'd2;
    localparam t_step STEP_SUMINIT = 4'd3;
    localparam t_step STEP_SUM     = 4'd4;
    localparam t_step STEP_CHECK   = 4'd5;
    localparam t_step STEP_COMMIT  = 4'd6;
    localparam t_step STEP_SHIFT   = 4'd7;
    localparam t_step STEP_EMIT    = 4'd8;
    localparam t_step STEP_RETURN  = 4'd9;
    localparam t_step STEP_FETCH   = 4'd10;

    typedef struct packed {
        logic  in_ready;
        logic  append;
        logic  sum_clr;
        logic  sum_add;
        logic  commit;
        logic  shift;
        logic  fetch;
        logic  emit;
        t_cond cond;
        t_step jmp;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic is_fetch;
        logic drop;
        logic not_full;
        logic sum_more;
        logic sum_bad;
        logic shift_more;
        logic out_blocked;
    } t_dp_flags;

    function automatic t_uword sbfr_rom(input t_step step);
        t_uword uw;
        uw      = '0;
        uw.cond = COND_ALWAYS;
        uw.jmp  = STEP_WAIT;
        unique case (step)
            STEP_WAIT: begin
                uw.in_ready = 1'b1;
                uw.cond     = COND_NOT_ACCEPT;
                uw.jmp      = STEP_WAIT;
            end
            STEP_DECODE: begin
                uw.cond = COND_IS_FETCH;
                uw.jmp  = STEP_FETCH;
            end
            STEP_APPEND: begin
                uw.append = 1'b1;
                uw.cond   = COND_DROP;
                uw.jmp    = STEP_EMIT;
            end
            STEP_SUMINIT: begin
                uw.sum_clr = 1'b1;
                uw.cond    = COND_NOT_FULL;
                uw.jmp     = STEP_EMIT;
            end
            STEP_SUM: begin
                uw.sum_add = 1'b1;
                uw.cond    = COND_SUM_MORE;
                uw.jmp     = STEP_SUM;
            end
            STEP_CHECK: begin
                uw.cond = COND_SUM_BAD;
                uw.jmp  = STEP_SHIFT;
            end
            STEP_COMMIT: begin
                uw.commit = 1'b1;
                uw.cond   = COND_ALWAYS;
                uw.jmp    = STEP_EMIT;
            end
            STEP_SHIFT: begin
                uw.shift = 1'b1;
                uw.cond  = COND_SHIFT_MORE;
                uw.jmp   = STEP_SHIFT;
            end
            STEP_EMIT: begin
                uw.emit = 1'b1;
                uw.cond = COND_OUT_BLOCKED;
                uw.jmp  = STEP_EMIT;
            end
            STEP_RETURN: begin
                uw.cond = COND_ALWAYS;
                uw.jmp  = STEP_WAIT;
            end
            STEP_FETCH: begin
                uw.fetch = 1'b1;
                uw.cond  = COND_ALWAYS;
                uw.jmp   = STEP_EMIT;
            end
            default: begin
                uw.cond = COND_ALWAYS;
                uw.jmp  = STEP_WAIT;
            end
        endcase
        return uw;
    endfunction

endpackage
`default_nettype wire

### sv/sbfr_sequencer.sv
// Microcode sequencer: step counter, program ROM and conditional jump select.
`timescale 1ns / 1ps
`default_nettype none
module sbfr_sequencer
    import sbfr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_dp_flags i_flags,
    output t_uword         o_uword
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_uword;
    logic   w_take;

    always_comb begin
        w_uword = sbfr_rom(r_step);
        unique case (w_uword.cond)
            COND_ALWAYS:      w_take = 1'b1;
            COND_NOT_ACCEPT:  w_take = !i_flags.in_valid;
            COND_IS_FETCH:    w_take = i_flags.is_fetch;
            COND_DROP:        w_take = i_flags.drop;
            COND_NOT_FULL:    w_take = i_flags.not_full;
            COND_SUM_MORE:    w_take = i_flags.sum_more;
            COND_SUM_BAD:     w_take = i_flags.sum_bad;
            COND_SHIFT_MORE:  w_take = i_flags.shift_more;
            COND_OUT_BLOCKED: w_take = i_flags.out_blocked;
            default:          w_take = 1'b1;
        endcase
        n_step = w_take ? w_uword.jmp : r_step + t_step'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uword = w_uword;

endmodule
`default_nettype wire

### sv/sbfr_datapath.sv
// Datapath: receive buffer, checksum accumulator, command store and output register.
`timescale 1ns / 1ps
`default_nettype none
module sbfr_datapath
    import sbfr_pkg::*;
#(
    parameter int unsigned FRAME_LENGTH = FRAME_LENGTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_uword    i_uword,
    input  wire logic      i_in_valid,
    input  wire t_in_word  i_in_word,
    input  wire logic      i_out_ready,
    output t_dp_flags      o_flags,
    output logic           o_out_valid,
    output t_out_word      o_out_word
);

    localparam int unsigned FW = $clog2(FRAME_LENGTH + 1);
    localparam int unsigned IW = $clog2(FRAME_LENGTH);
    localparam logic [FW-1:0] FILL_FULL = FW'(FRAME_LENGTH);
    localparam logic [IW-1:0] LAST_SUM  = IW'(FRAME_LENGTH - 2);
    localparam logic [7:0]    REQ_LEN   = 8'(FRAME_LENGTH);

    t_in_word     r_item;
    logic [7:0]   r_buf    [FRAME_LENGTH];
    logic [7:0]   r_latest [FRAME_LENGTH];
    logic [FW-1:0] r_fill;
    logic [IW-1:0] r_idx;
    logic [7:0]   r_sum;
    logic         r_flag;
    t_out_word    r_res;
    logic         r_out_valid;
    t_out_word    r_out;
    logic         w_drop;
    logic         w_load;
    logic [63:0]  w_cmd;

    assign w_drop = (r_fill == '0) && (r_item.rx_byte != START_BYTE);
    assign w_load = !r_out_valid || i_out_ready;

    always_comb begin
        w_cmd = '0;
        for (int i = 0; i < FRAME_LENGTH; i++) begin
            w_cmd[8*i +: 8] = r_latest[i];
        end
    end

    always_comb begin
        o_flags.in_valid    = i_in_valid;
        o_flags.is_fetch    = r_item.action;
        o_flags.drop        = w_drop;
        o_flags.not_full    = r_fill != FILL_FULL;
        o_flags.sum_more    = r_idx != LAST_SUM;
        o_flags.sum_bad     = r_sum != r_buf[FRAME_LENGTH-1];
        o_flags.shift_more  = !((r_buf[1] == START_BYTE) || (r_fill == FW'(1)));
        o_flags.out_blocked = !w_load;
    end

    always_ff @(posedge i_clk) begin
        if (i_uword.in_ready && i_in_valid) begin
            r_item <= i_in_word;
            r_res  <= '0;
        end
        if (i_uword.append && !w_drop) begin
            for (int i = 0; i < FRAME_LENGTH; i++) begin
                if (r_fill == FW'(i)) begin
                    r_buf[i] <= r_item.rx_byte;
                end
            end
        end
        if (i_uword.sum_clr) begin
            r_sum <= '0;
            r_idx <= '0;
        end
        if (i_uword.sum_add) begin
            r_sum <= r_sum + r_buf[r_idx];
            r_idx <= r_idx + IW'(1);
        end
        if (i_uword.commit) begin
            r_res.frame_accepted <= 1'b1;
        end
        if (i_uword.shift) begin
            for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
            r_res.frame_rejected <= 1'b1;
        end
        if (i_uword.fetch) begin
            if ((r_item.requested_length != REQ_LEN) || !r_flag) begin
                r_res.fetch_status <= 1'b1;
            end else begin
                r_res.command_data <= w_cmd;
            end
        end
        if (i_uword.emit && w_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < FRAME_LENGTH; i++) begin
                r_latest[i] <= '0;
            end
        end else begin
            if (i_uword.append && !w_drop) begin
                r_fill <= r_fill + FW'(1);
            end
            if (i_uword.commit) begin
                for (int i = 0; i < FRAME_LENGTH; i++) begin
                    r_latest[i] <= r_buf[i];
                end
                r_fill <= '0;
                r_flag <= 1'b1;
            end
            if (i_uword.shift) begin
                r_fill <= r_fill - FW'(1);
            end
            if (i_uword.fetch && (r_item.requested_length == REQ_LEN) && r_flag) begin
                r_flag <= 1'b0;
            end
            if (i_uword.emit && w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
`default_nettype wire

### sv/sync_byte_frame_receiver.sv
// From acceptance to the output register a dropped byte passes steps DECODE and APPEND, a fetch DECODE
// and FETCH, a buffered byte DECODE, APPEND and SUMINIT; a completing byte then runs the SUM loop and
// CHECK, then COMMIT on a good checksum or the SHIFT loop on a bad one. The checksum and realignment
// loops of the microprogram visit one buffered byte per cycle. One item at a time; the next is accepted
// in WAIT, via RETURN, once EMIT has loaded the result into the output register, waiting out any output stall.
// Reset (synchronous, active low) empties the buffer, clears the command store, the flag and o_out_valid.
`timescale 1ns / 1ps
`default_nettype none
module sync_byte_frame_receiver
    import sbfr_pkg::*;
#(
    parameter int unsigned FRAME_LENGTH = FRAME_LENGTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    t_uword    w_uword;
    t_dp_flags w_flags;

    sbfr_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uword (w_uword)
    );

    sbfr_datapath #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (w_uword),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .o_flags     (w_flags),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    assign o_in_ready = w_uword.in_ready;

endmodule
`default_nettype wire
